// ===== sv/tsjd_pkg.sv =====
// ----------------------------------------------------------------------------
// tsjd_pkg
// Shared types, widths and helpers for the three-server job dispatcher.
// ----------------------------------------------------------------------------
package tsjd_pkg;

  localparam int SERVERS   = 3;
  localparam int SRV_W     = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int OUT_SRV_W = 2;
  localparam int DUR_W     = 32;
  localparam int TIME_W    = 64;

  // job queue between front and back
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [DUR_W-1:0] duration;
    logic             first;
  } job_t;

  typedef struct packed {
    logic              valid;
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

// ===== sv/tsjd_front.sv =====
// ----------------------------------------------------------------------------
// tsjd_front
// Input stage: takes a job from the input channel, packs it and hands it to
// the job queue.
// ----------------------------------------------------------------------------
module tsjd_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [tsjd_pkg::DUR_W-1:0] in_duration,
  input  logic                       in_first,
  input  tsjd_pkg::q_stat_t          q_stat,
  output logic                       push,
  output tsjd_pkg::job_t             push_job
);

  logic           item_v_r;
  logic           item_v_nxt;
  tsjd_pkg::job_t item_r;
  logic           load;

  // holding register only blocks when the queue cannot take it
  assign in_stall = item_v_r && q_stat.full;
  assign load     = in_valid && !in_stall;
  assign push     = item_v_r && !q_stat.full;
  assign push_job = item_r;

  always_comb begin
    item_v_nxt = item_v_r;
    if (load) begin
      item_v_nxt = 1'b1;
    end else if (push) begin
      item_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.duration <= in_duration;
      item_r.first    <= in_first;
    end
  end

endmodule

// ===== sv/tsjd_queue.sv =====
// ----------------------------------------------------------------------------
// tsjd_queue
// Short FIFO of packed jobs between the input stage and the dispatch engine.
// ----------------------------------------------------------------------------
module tsjd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tsjd_pkg::job_t    push_job,
  input  logic              pop,
  output tsjd_pkg::job_t    pop_job,
  output tsjd_pkg::q_stat_t q_stat
);

  tsjd_pkg::job_t                    entry_r [tsjd_pkg::QDEPTH];
  logic [tsjd_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [tsjd_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [tsjd_pkg::QCNT_W-1:0]       count_r, count_nxt;
  logic                              do_push, do_pop;

  assign q_stat.count = count_r;
  assign q_stat.valid = (count_r != '0);
  assign q_stat.full  = (count_r == tsjd_pkg::QCNT_W'(tsjd_pkg::QDEPTH));
  assign pop_job      = entry_r[rd_ptr_r];

  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && q_stat.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == tsjd_pkg::QDEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == tsjd_pkg::QDEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== sv/tsjd_back.sv =====
// ----------------------------------------------------------------------------
// tsjd_back
// Dispatch engine: applies both policies to one job per cycle unless
// stalled, keeps the per-server state and holds the result register.
// ----------------------------------------------------------------------------
module tsjd_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tsjd_pkg::q_stat_t              q_stat,
  input  tsjd_pkg::job_t                 job,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tsjd_pkg::OUT_SRV_W-1:0] out_cyclic_server,
  output logic [tsjd_pkg::TIME_W-1:0]    out_cyclic_total_wait,
  output logic [tsjd_pkg::TIME_W-1:0]    out_cyclic_makespan,
  output logic [tsjd_pkg::OUT_SRV_W-1:0] out_earliest_server,
  output logic [tsjd_pkg::TIME_W-1:0]    out_earliest_total_wait,
  output logic [tsjd_pkg::TIME_W-1:0]    out_earliest_makespan
);

  localparam int N  = tsjd_pkg::SERVERS;
  localparam int SW = tsjd_pkg::SRV_W;
  localparam int TW = tsjd_pkg::TIME_W;

  logic [SW-1:0] ptr_r, ptr_nxt;
  logic [TW-1:0] busy_r [N];
  logic [TW-1:0] busy_nxt [N];
  logic [TW-1:0] cwait_r, cwait_nxt;
  logic [TW-1:0] free_r [N];
  logic [TW-1:0] free_nxt [N];
  logic [TW-1:0] ewait_r, ewait_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [SW-1:0] ptr_cur, a_idx, b_idx;
  logic [TW-1:0] busy_cur [N];
  logic [TW-1:0] free_cur [N];
  logic [TW-1:0] dur_ext, start, cmax, emax;

  logic [tsjd_pkg::OUT_SRV_W-1:0] cserv_r, eserv_r;
  logic [TW-1:0]                  cwait_o_r, cmax_r, ewait_o_r, emax_r;

  assign pop = q_stat.valid && (!out_valid_r || !out_stall);

  always_comb begin
    dur_ext = TW'(job.duration);
    ptr_cur = job.first ? '0 : ptr_r;
    a_idx   = (32'(ptr_cur) >= N) ? '0 : ptr_cur;
    ptr_nxt = (32'(a_idx) + 1 >= N) ? '0 : a_idx + 1'b1;

    for (int i = 0; i < N; i++) begin
      busy_cur[i] = job.first ? '0 : busy_r[i];
      free_cur[i] = job.first ? '0 : free_r[i];
    end

    // cyclic: wait for what is already queued on the pointed server
    cwait_nxt = tsjd_pkg::sat_add(job.first ? '0 : cwait_r, busy_cur[a_idx]);
    busy_nxt  = busy_cur;
    busy_nxt[a_idx] = tsjd_pkg::sat_add(busy_cur[a_idx], dur_ext);

    // earliest-free: strict less-than keeps the lowest index on ties
    b_idx = '0;
    for (int i = 1; i < N; i++) begin
      if (free_cur[i] < free_cur[b_idx]) begin
        b_idx = SW'(i);
      end
    end
    start     = free_cur[b_idx];
    ewait_nxt = tsjd_pkg::sat_add(job.first ? '0 : ewait_r, start);
    free_nxt  = free_cur;
    free_nxt[b_idx] = tsjd_pkg::sat_add(start, dur_ext);

    cmax = busy_nxt[0];
    emax = free_nxt[0];
    for (int i = 1; i < N; i++) begin
      if (busy_nxt[i] > cmax) begin
        cmax = busy_nxt[i];
      end
      if (free_nxt[i] > emax) begin
        emax = free_nxt[i];
      end
    end

    out_valid_nxt = pop ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ptr_r       <= '0;
      cwait_r     <= '0;
      ewait_r     <= '0;
      for (int i = 0; i < N; i++) begin
        busy_r[i] <= '0;
        free_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        ptr_r   <= ptr_nxt;
        cwait_r <= cwait_nxt;
        ewait_r <= ewait_nxt;
        for (int i = 0; i < N; i++) begin
          busy_r[i] <= busy_nxt[i];
          free_r[i] <= free_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cserv_r   <= tsjd_pkg::OUT_SRV_W'(a_idx);
      cwait_o_r <= cwait_nxt;
      cmax_r    <= cmax;
      eserv_r   <= tsjd_pkg::OUT_SRV_W'(b_idx);
      ewait_o_r <= ewait_nxt;
      emax_r    <= emax;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_cyclic_server       = cserv_r;
  assign out_cyclic_total_wait   = cwait_o_r;
  assign out_cyclic_makespan     = cmax_r;
  assign out_earliest_server     = eserv_r;
  assign out_earliest_total_wait = ewait_o_r;
  assign out_earliest_makespan   = emax_r;

endmodule

// ===== sv/three_server_job_dispatch.sv =====
// ----------------------------------------------------------------------------
// three_server_job_dispatch
// Greedy list scheduling of a job stream onto three servers, two policies.
// ----------------------------------------------------------------------------
// Takes one job per cycle while out_stall is low, and returns one result per
// job in order. An accepted job passes the input register, the two-entry job
// queue and the result register on its way to the result channel. The rate
// is set by the per-server state loop in the dispatch engine: the minimum
// over the free times, the saturating adds and the makespan maximum are all
// combinational. in_first set on a job starts a new batch with all state
// cleared. Result stalls back up through the queue; the input stalls only
// once the queue and the input register are both full.
module three_server_job_dispatch (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tsjd_pkg::DUR_W-1:0]     in_duration,
  input  logic                           in_first,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tsjd_pkg::OUT_SRV_W-1:0] out_cyclic_server,
  output logic [tsjd_pkg::TIME_W-1:0]    out_cyclic_total_wait,
  output logic [tsjd_pkg::TIME_W-1:0]    out_cyclic_makespan,
  output logic [tsjd_pkg::OUT_SRV_W-1:0] out_earliest_server,
  output logic [tsjd_pkg::TIME_W-1:0]    out_earliest_total_wait,
  output logic [tsjd_pkg::TIME_W-1:0]    out_earliest_makespan
);

  tsjd_pkg::q_stat_t q_stat;
  tsjd_pkg::job_t    push_job, pop_job;
  logic              push, pop;

  tsjd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_duration(in_duration),
    .in_first   (in_first),
    .q_stat     (q_stat),
    .push       (push),
    .push_job   (push_job)
  );

  tsjd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .pop_job (pop_job),
    .q_stat  (q_stat)
  );

  tsjd_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .q_stat                 (q_stat),
    .job                    (pop_job),
    .pop                    (pop),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_cyclic_server      (out_cyclic_server),
    .out_cyclic_total_wait  (out_cyclic_total_wait),
    .out_cyclic_makespan    (out_cyclic_makespan),
    .out_earliest_server    (out_earliest_server),
    .out_earliest_total_wait(out_earliest_total_wait),
    .out_earliest_makespan  (out_earliest_makespan)
  );

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(q_stat.count) <= tsjd_pkg::QDEPTH)
    else $error("job queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.valid)
    else $error("pop from empty job queue");

  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid)
    else $error("popped job produced no result");

  a_srv_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (tsjd_pkg::SERVERS > 4) ||
                  (32'(out_cyclic_server) < tsjd_pkg::SERVERS &&
                   32'(out_earliest_server) < tsjd_pkg::SERVERS))
    else $error("server index out of range");

endmodule
